// File: hw/rtl/gf3x3_pkg.sv
// Shared types and constants of the 3x3 gap filling filter.
// No dependencies; the RTL files but gf3x3_ram refer to it by scoped names, the testbench imports it.
package gf3x3_pkg;

   localparam int PIX_W       = 8;
   localparam int FW_W        = 12;
   localparam int FH_W        = 16;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int MIN_FRAME   = 3;

   typedef logic [PIX_W-1:0] pixel_type;
   typedef logic [1:0]       slot_type;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DARK_LEVEL   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FILL_VALUE   = 2'd3;

   // Request operation codes.
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 16'd480;
   localparam pixel_type       DARK_LEVEL_RESET   = 8'd64;
   localparam pixel_type       FILL_VALUE_RESET   = 8'd64;

   // Issue information for one output pixel, handed from the tracker to the kernel stage.
   typedef struct packed {
      logic     emit;
      logic     border;
      logic     frame_end;
      slot_type mid_slot;
      slot_type below_slot;
      logic     above_slot;
      logic     done_slot;
      logic     snoop_hit;
   } issue_type;

   // The 3x3 neighbourhood of the pixel being cleaned.
   typedef struct packed {
      pixel_type centre;
      pixel_type left;
      pixel_type right;
      pixel_type up_left;
      pixel_type up;
      pixel_type up_right;
      pixel_type down_left;
      pixel_type down;
      pixel_type down_right;
   } window_type;

endpackage

// File: hw/rtl/gf3x3_if.sv
// Valid/ready stream interfaces for the requests and responses of the gap filling filter.
// Depends on gf3x3_pkg for the pixel type.
interface gf3x3_req_if;
   logic                  valid;
   logic                  ready;
   logic                  op;
   gf3x3_pkg::pixel_type  pixel_in;

   modport source (output valid, output op, output pixel_in, input ready);
   modport sink   (input valid, input op, input pixel_in, output ready);
endinterface

interface gf3x3_rsp_if;
   logic                  valid;
   logic                  ready;
   gf3x3_pkg::pixel_type  pixel_out;
   logic                  frame_end;

   modport source (output valid, output pixel_out, output frame_end, input ready);
   modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

// File: hw/rtl/gf3x3_ram.sv
// Generic simple dual-port RAM: one write port and two registered read ports.
// No dependencies.
module gf3x3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] data_a_ff;
   logic [WIDTH-1:0] data_b_ff;

   // A read of the address being written returns the new data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         data_a_ff <= (wr_en && wr_addr == rd_addr_a) ? wr_data : mem[rd_addr_a];
         data_b_ff <= (wr_en && wr_addr == rd_addr_b) ? wr_data : mem[rd_addr_b];
      end
   end

   assign rd_data_a = data_a_ff;
   assign rd_data_b = data_b_ff;

endmodule

// File: hw/rtl/gf3x3_track.sv
// Stream position tracking of the gap filling filter: input and output positions,
// line buffer slots and the pending count. Depends on gf3x3_pkg.
module gf3x3_track #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           restart,
   input  logic                           accept,
   input  logic                           op,
   input  logic [gf3x3_pkg::FW_W-1:0]     frame_width,
   input  logic [gf3x3_pkg::FH_W-1:0]     frame_height,
   output gf3x3_pkg::issue_type           issue,
   output logic [$clog2(MAX_WIDTH)-1:0]   rd_col,
   output logic [$clog2(MAX_WIDTH)-1:0]   rd_col_next,
   output logic                           wr_en,
   output gf3x3_pkg::slot_type            wr_slot,
   output logic [$clog2(MAX_WIDTH)-1:0]   wr_col
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int PW = $clog2(MAX_WIDTH + 2);

   logic [CW-1:0]                  in_col_ff, in_col_in;
   gf3x3_pkg::slot_type            in_slot_ff, in_slot_in;
   logic [CW-1:0]                  out_col_ff, out_col_in;
   logic [gf3x3_pkg::FH_W-1:0]     out_row_ff, out_row_in;
   gf3x3_pkg::slot_type            out_slot_ff, out_slot_in;
   logic                           done_slot_ff, done_slot_in;
   logic [PW-1:0]                  pending_ff, pending_in;

   logic [CW-1:0]                  w_last;
   logic [gf3x3_pkg::FH_W-1:0]     h_last;
   logic [PW-1:0]                  w_full;
   logic                           is_pixel;
   logic                           emit;
   logic                           in_col_last;
   logic                           out_col_last;
   gf3x3_pkg::slot_type            below_slot;

   function automatic gf3x3_pkg::slot_type slot_next(input gf3x3_pkg::slot_type s);
      slot_next = (s == 2'd2) ? 2'd0 : s + 2'd1;
   endfunction

   // Effective geometry: width clamped to the line buffer, both at least three.
   always_comb begin
      if (frame_width < gf3x3_pkg::FW_W'(gf3x3_pkg::MIN_FRAME)) begin
         w_last = CW'(gf3x3_pkg::MIN_FRAME - 1);
      end else if (32'(frame_width) > MAX_WIDTH) begin
         w_last = CW'(MAX_WIDTH - 1);
      end else begin
         w_last = CW'(frame_width - gf3x3_pkg::FW_W'(1));
      end
      if (frame_height < gf3x3_pkg::FH_W'(gf3x3_pkg::MIN_FRAME)) begin
         h_last = gf3x3_pkg::FH_W'(gf3x3_pkg::MIN_FRAME - 1);
      end else begin
         h_last = frame_height - gf3x3_pkg::FH_W'(1);
      end
   end

   assign w_full       = PW'(w_last) + PW'(1);
   assign is_pixel     = (op == gf3x3_pkg::OP_PIXEL);
   assign emit         = accept && (is_pixel ? (pending_ff > w_full) : (pending_ff != '0));
   assign in_col_last  = (in_col_ff == w_last);
   assign out_col_last = (out_col_ff == w_last);
   assign below_slot   = slot_next(out_slot_ff);

   assign wr_en       = accept && is_pixel;
   assign wr_slot     = in_slot_ff;
   assign wr_col      = in_col_ff;
   assign rd_col      = out_col_ff;
   assign rd_col_next = out_col_last ? '0 : out_col_ff + CW'(1);

   always_comb begin
      issue.emit       = emit;
      issue.border     = (out_row_ff == '0) || (out_row_ff == h_last) ||
                         (out_col_ff == '0) || out_col_last;
      issue.frame_end  = (out_row_ff == h_last) && out_col_last;
      issue.mid_slot   = out_slot_ff;
      issue.below_slot = below_slot;
      issue.above_slot = ~done_slot_ff;
      issue.done_slot  = done_slot_ff;
      // The incoming pixel lands on the lower left neighbour of the next output pixel.
      issue.snoop_hit  = wr_en && (in_slot_ff == below_slot) && (out_col_ff != '0) &&
                         (in_col_ff == out_col_ff - CW'(1));
   end

   always_comb begin
      in_col_in    = in_col_ff;
      in_slot_in   = in_slot_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      out_slot_in  = out_slot_ff;
      done_slot_in = done_slot_ff;
      pending_in   = pending_ff;
      if (wr_en) begin
         if (in_col_last) begin
            in_col_in  = '0;
            in_slot_in = slot_next(in_slot_ff);
         end else begin
            in_col_in  = in_col_ff + CW'(1);
         end
      end
      if (emit) begin
         if (out_col_last) begin
            out_col_in   = '0;
            out_slot_in  = slot_next(out_slot_ff);
            done_slot_in = ~done_slot_ff;
            out_row_in   = (out_row_ff == h_last) ? '0 : out_row_ff + gf3x3_pkg::FH_W'(1);
         end else begin
            out_col_in   = out_col_ff + CW'(1);
         end
      end
      if (wr_en && !emit) begin
         pending_in = pending_ff + PW'(1);
      end else if (!wr_en && emit) begin
         pending_in = pending_ff - PW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         in_col_ff    <= '0;
         in_slot_ff   <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         out_slot_ff  <= '0;
         done_slot_ff <= 1'b0;
         pending_ff   <= '0;
      end else begin
         in_col_ff    <= in_col_in;
         in_slot_ff   <= in_slot_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         out_slot_ff  <= out_slot_in;
         done_slot_ff <= done_slot_in;
         pending_ff   <= pending_in;
      end
   end

endmodule

// File: hw/rtl/gf3x3_gap_test.sv
// Gap test of the filter: decides whether a bright interior pixel is filled.
// Depends on gf3x3_pkg for the neighbourhood type.
module gf3x3_gap_test (
   input  logic                  interior,
   input  gf3x3_pkg::pixel_type  dark_level,
   input  gf3x3_pkg::pixel_type  fill_value,
   input  gf3x3_pkg::window_type window,
   output gf3x3_pkg::pixel_type  result
);

   logic dark_l, dark_r, dark_ul, dark_u, dark_ur, dark_dl, dark_d, dark_dr;
   logic gap;

   assign dark_l  = window.left < dark_level;
   assign dark_r  = window.right < dark_level;
   assign dark_ul = window.up_left < dark_level;
   assign dark_u  = window.up < dark_level;
   assign dark_ur = window.up_right < dark_level;
   assign dark_dl = window.down_left < dark_level;
   assign dark_d  = window.down < dark_level;
   assign dark_dr = window.down_right < dark_level;

   // Any opposite pair that is dark on both sides marks a gap.
   assign gap = (dark_l && dark_r) || (dark_u && dark_d) ||
                (dark_ul && dark_dr) || (dark_ur && dark_dl);

   always_comb begin
      result = window.centre;
      if (interior) begin
         if (window.centre > dark_level && gap) begin
            result = fill_value;
         end
      end
   end

endmodule

// File: hw/rtl/gap_fill_3x3_filter.sv
// Top level of the streaming 3x3 gap filling filter for 8-bit gray frames.
// Depends on gf3x3_pkg, gf3x3_if, gf3x3_ram, gf3x3_track and gf3x3_gap_test.
//
//   Channel   Direction  Handshake         Carries
//   req_port  in         valid / ready     op, pixel_in
//   rsp_port  out        valid / ready     pixel_out, frame_end
//   csr_*     in         write enable      register index, write data
//
// One request is taken every clock while the request side is not stalled. A request that
// releases an output pixel reads the line buffers at its accepting edge; the pixel is then
// cleaned in the kernel stage and loaded from there into the response register, from which
// it is offered.
// The line buffers are not cleared by reset; reset and a geometry write restart the stream.
// When the response is held and the kernel stage holds a pixel, the request side stalls.
module gap_fill_3x3_filter #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                                  clock,
   input  logic                                  reset,
   gf3x3_req_if.sink                             req_port,
   gf3x3_rsp_if.source                           rsp_port,
   input  logic                                  csr_write_enable,
   input  logic [gf3x3_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [gf3x3_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   localparam int CW = $clog2(MAX_WIDTH);

   // Configuration registers.
   logic [gf3x3_pkg::FW_W-1:0] frame_width_ff;
   logic [gf3x3_pkg::FH_W-1:0] frame_height_ff;
   gf3x3_pkg::pixel_type       dark_level_ff;
   gf3x3_pkg::pixel_type       fill_value_ff;
   logic                       restart;

   // Handshake and tracker signals.
   logic                 accept;
   logic                 out_free;
   logic                 b_done;
   gf3x3_pkg::issue_type issue;
   logic [CW-1:0]        rd_col;
   logic [CW-1:0]        rd_col_next;
   logic                 raw_wr_en;
   gf3x3_pkg::slot_type  raw_wr_slot;
   logic [CW-1:0]        raw_wr_col;

   // Line buffer read data: three raw rows and two cleaned rows.
   gf3x3_pkg::pixel_type raw_a [3];
   gf3x3_pkg::pixel_type raw_b [3];
   gf3x3_pkg::pixel_type done_a [2];
   gf3x3_pkg::pixel_type done_b [2];
   gf3x3_pkg::pixel_type mid_a, mid_b, below_a, below_b;

   // Kernel stage.
   logic                 b_valid_ff, b_valid_in;
   gf3x3_pkg::issue_type b_issue_ff;
   logic [CW-1:0]        b_col_ff;
   gf3x3_pkg::pixel_type left_ff, left_in;
   gf3x3_pkg::pixel_type up_left_ff, up_left_in;
   gf3x3_pkg::pixel_type down_left_ff, down_left_in;
   gf3x3_pkg::window_type window;
   gf3x3_pkg::pixel_type cleaned;

   // Response register.
   logic                 rsp_valid_ff, rsp_valid_in;
   gf3x3_pkg::pixel_type pixel_out_ff;
   logic                 frame_end_ff;

   // A write to either geometry register restarts the stream.
   assign restart = csr_write_enable &&
                    (csr_index == gf3x3_pkg::CSR_FRAME_WIDTH ||
                     csr_index == gf3x3_pkg::CSR_FRAME_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= gf3x3_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= gf3x3_pkg::FRAME_HEIGHT_RESET;
         dark_level_ff   <= gf3x3_pkg::DARK_LEVEL_RESET;
         fill_value_ff   <= gf3x3_pkg::FILL_VALUE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            gf3x3_pkg::CSR_FRAME_WIDTH: begin
               frame_width_ff <= csr_write_data[gf3x3_pkg::FW_W-1:0];
            end
            gf3x3_pkg::CSR_FRAME_HEIGHT: begin
               frame_height_ff <= csr_write_data[gf3x3_pkg::FH_W-1:0];
            end
            gf3x3_pkg::CSR_DARK_LEVEL: begin
               dark_level_ff <= csr_write_data[gf3x3_pkg::PIX_W-1:0];
            end
            gf3x3_pkg::CSR_FILL_VALUE: begin
               fill_value_ff <= csr_write_data[gf3x3_pkg::PIX_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // The kernel stage moves on when the response register is empty or being emptied.
   // A new request is taken when the kernel stage is empty or moves on in this cycle.
   assign out_free       = !rsp_valid_ff || rsp_port.ready;
   assign b_done         = b_valid_ff && out_free;
   assign req_port.ready = !b_valid_ff || out_free;
   assign accept         = req_port.valid && req_port.ready;

   gf3x3_track #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_track (
      .clock        (clock),
      .reset        (reset),
      .restart      (restart),
      .accept       (accept),
      .op           (req_port.op),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .issue        (issue),
      .rd_col       (rd_col),
      .rd_col_next  (rd_col_next),
      .wr_en        (raw_wr_en),
      .wr_slot      (raw_wr_slot),
      .wr_col       (raw_wr_col)
   );

   // Raw rows are read at the output column and the one to its right, for the middle row
   // and the row below alike; the slot is picked in the kernel stage.
   for (genvar s = 0; s < 3; s++) begin : g_raw
      gf3x3_ram #(
         .WIDTH (gf3x3_pkg::PIX_W),
         .DEPTH (MAX_WIDTH)
      ) u_raw (
         .clock     (clock),
         .wr_en     (raw_wr_en && raw_wr_slot == 2'(s)),
         .wr_addr   (raw_wr_col),
         .wr_data   (req_port.pixel_in),
         .rd_en     (issue.emit),
         .rd_addr_a (rd_col),
         .rd_addr_b (rd_col_next),
         .rd_data_a (raw_a[s]),
         .rd_data_b (raw_b[s])
      );
   end

   // Cleaned rows: the kernel stage writes the current row while it reads the row above.
   for (genvar s = 0; s < 2; s++) begin : g_done
      gf3x3_ram #(
         .WIDTH (gf3x3_pkg::PIX_W),
         .DEPTH (MAX_WIDTH)
      ) u_done (
         .clock     (clock),
         .wr_en     (b_done && b_issue_ff.done_slot == 1'(s)),
         .wr_addr   (b_col_ff),
         .wr_data   (cleaned),
         .rd_en     (issue.emit),
         .rd_addr_a (rd_col),
         .rd_addr_b (rd_col_next),
         .rd_data_a (done_a[s]),
         .rd_data_b (done_b[s])
      );
   end

   always_comb begin
      case (b_issue_ff.mid_slot)
         2'd1: begin
            mid_a = raw_a[1];
            mid_b = raw_b[1];
         end
         2'd2: begin
            mid_a = raw_a[2];
            mid_b = raw_b[2];
         end
         default: begin
            mid_a = raw_a[0];
            mid_b = raw_b[0];
         end
      endcase
      case (b_issue_ff.below_slot)
         2'd1: begin
            below_a = raw_a[1];
            below_b = raw_b[1];
         end
         2'd2: begin
            below_a = raw_a[2];
            below_b = raw_b[2];
         end
         default: begin
            below_a = raw_a[0];
            below_b = raw_b[0];
         end
      endcase
   end

   // The left column of the window comes from registers: the cleaned left pixel, the
   // cleaned pixel above it and the raw pixel below it, all saved by the previous pixel.
   always_comb begin
      window.centre     = mid_a;
      window.left       = left_ff;
      window.right      = mid_b;
      window.up_left    = up_left_ff;
      window.up         = done_a[b_issue_ff.above_slot];
      window.up_right   = done_b[b_issue_ff.above_slot];
      window.down_left  = down_left_ff;
      window.down       = below_a;
      window.down_right = below_b;
   end

   gf3x3_gap_test u_gap_test (
      .interior   (!b_issue_ff.border),
      .dark_level (dark_level_ff),
      .fill_value (fill_value_ff),
      .window     (window),
      .result     (cleaned)
   );

   // The lower left register is refreshed when the pixel it stands for arrives late,
   // which happens after flushes have drained the stream ahead of the input.
   always_comb begin
      b_valid_in   = issue.emit || (b_valid_ff && !b_done);
      left_in      = b_done ? cleaned : left_ff;
      up_left_in   = b_done ? window.up : up_left_ff;
      down_left_in = down_left_ff;
      if (issue.snoop_hit) begin
         down_left_in = req_port.pixel_in;
      end else if (b_done) begin
         down_left_in = below_a;
      end
      rsp_valid_in = b_done || (rsp_valid_ff && !rsp_port.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         left_ff      <= '0;
      end else begin
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         left_ff      <= restart ? '0 : left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue.emit) begin
         b_issue_ff <= issue;
         b_col_ff   <= rd_col;
      end
      up_left_ff   <= up_left_in;
      down_left_ff <= down_left_in;
      if (b_done) begin
         pixel_out_ff <= cleaned;
         frame_end_ff <= b_issue_ff.frame_end;
      end
   end

   assign rsp_port.valid     = rsp_valid_ff;
   assign rsp_port.pixel_out = pixel_out_ff;
   assign rsp_port.frame_end = frame_end_ff;

endmodule

// File: tb/sv/gf3x3_board_pkg.sv
// Scoreboard for the 3x3 gap filling filter: predicts every cleaned pixel and checks responses.
// Depends on gf3x3_pkg for the pixel type, register indexes and operation codes.
package gf3x3_board_pkg;

   import gf3x3_pkg::*;

   localparam int LINE_DEPTH = 2048;

   typedef struct packed {
      pixel_type pixel_out;
      logic      frame_end;
   } cleaned_type;

   class cleaned_frame_board;

      logic [FW_W-1:0] width_reg;
      logic [FH_W-1:0] height_reg;
      pixel_type       dark;
      pixel_type       fill;

      // Three raw rows in rotation and two cleaned rows in ping-pong.
      pixel_type   raw_rows [3][LINE_DEPTH];
      pixel_type   clean_rows [2][LINE_DEPTH];
      pixel_type   left_clean;
      int unsigned in_col, in_row, out_col, out_row;
      int unsigned in_slot, out_slot, clean_slot, backlog;

      cleaned_type cleaned_due [$];
      int unsigned failures;

      function new();
         width_reg  = FRAME_WIDTH_RESET;
         height_reg = FRAME_HEIGHT_RESET;
         dark       = DARK_LEVEL_RESET;
         fill       = FILL_VALUE_RESET;
         for (int s = 0; s < 3; s++) begin
            for (int c = 0; c < LINE_DEPTH; c++) begin
               raw_rows[s][c] = '0;
               if (s < 2) begin
                  clean_rows[s][c] = '0;
               end
            end
         end
         failures = 0;
         restart();
      endfunction

      function void restart();
         left_clean = '0;
         in_col     = 0;
         in_row     = 0;
         out_col    = 0;
         out_row    = 0;
         in_slot    = 0;
         out_slot   = 0;
         clean_slot = 0;
         backlog    = 0;
      endfunction

      function int unsigned span();
         if (width_reg < MIN_FRAME) begin
            return MIN_FRAME;
         end
         if (width_reg > LINE_DEPTH) begin
            return LINE_DEPTH;
         end
         return width_reg;
      endfunction

      function int unsigned depth_rows();
         return (height_reg < MIN_FRAME) ? MIN_FRAME : height_reg;
      endfunction

      function bit is_dark(pixel_type v);
         return v < dark;
      endfunction

      function int unsigned outstanding();
         return cleaned_due.size();
      endfunction

      function void note_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_FRAME_WIDTH: begin
               width_reg = data[FW_W-1:0];
               restart();
            end
            CSR_FRAME_HEIGHT: begin
               height_reg = data[FH_W-1:0];
               restart();
            end
            CSR_DARK_LEVEL: dark = data[PIX_W-1:0];
            CSR_FILL_VALUE: fill = data[PIX_W-1:0];
            default: ;
         endcase
      endfunction

      // Cleans the oldest pending pixel in place and queues it as due.
      function void clean_next_pixel();
         int unsigned w, h, c, mid, below, above;
         pixel_type   d;
         cleaned_type item;
         w     = span();
         h     = depth_rows();
         c     = out_col;
         mid   = out_slot;
         below = (out_slot + 1) % 3;
         above = clean_slot ^ 1;
         d     = raw_rows[mid][c];
         if (out_row != 0 && out_row != h - 1 && c != 0 && c != w - 1 && d > dark) begin
            if ((is_dark(left_clean) && is_dark(raw_rows[mid][c+1])) ||
                (is_dark(clean_rows[above][c]) && is_dark(raw_rows[below][c])) ||
                (is_dark(clean_rows[above][c-1]) && is_dark(raw_rows[below][c+1])) ||
                (is_dark(clean_rows[above][c+1]) && is_dark(raw_rows[below][c-1]))) begin
               d = fill;
            end
         end
         clean_rows[clean_slot][c] = d;
         left_clean                = d;
         item.pixel_out            = d;
         item.frame_end            = (out_row == h - 1) && (c == w - 1);
         cleaned_due.push_back(item);
         out_col++;
         if (out_col >= w) begin
            out_col    = 0;
            out_slot   = (out_slot + 1) % 3;
            clean_slot = clean_slot ^ 1;
            out_row++;
            if (out_row >= h) begin
               out_row = 0;
            end
         end
         backlog--;
      endfunction

      function void note_request(logic op, pixel_type pix);
         int unsigned w;
         w = span();
         if (op == OP_PIXEL) begin
            raw_rows[in_slot][in_col] = pix;
            in_col++;
            if (in_col >= w) begin
               in_col  = 0;
               in_slot = (in_slot + 1) % 3;
               in_row++;
               if (in_row >= depth_rows()) begin
                  in_row = 0;
               end
            end
            backlog++;
            if (backlog > w + 1) begin
               clean_next_pixel();
            end
         end else if (backlog > 0) begin
            clean_next_pixel();
         end
      endfunction

      function void check_response(pixel_type pix, logic frame_end);
         cleaned_type due;
         if (cleaned_due.size() == 0) begin
            $error("response with nothing due: pixel_out %0d frame_end %0b", pix, frame_end);
            failures++;
         end else begin
            due = cleaned_due.pop_front();
            if (due.pixel_out !== pix) begin
               $error("pixel_out: expected %0d, actual %0d", due.pixel_out, pix);
               failures++;
            end
            if (due.frame_end !== frame_end) begin
               $error("frame_end: expected %0b, actual %0b", due.frame_end, frame_end);
               failures++;
            end
         end
      endfunction

   endclass

endpackage

// File: tb/sv/testbench.sv
// Self-checking testbench of gap_fill_3x3_filter: drives requests and register writes,
// predicts every cleaned pixel and checks the responses in order.
// Depends on gf3x3_pkg, gf3x3_if, gf3x3_board_pkg and the filter RTL.
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   import gf3x3_pkg::*;
   import gf3x3_board_pkg::*;

   // Quiet allowed after the last predicted pixel has come out and before the registers are
   // touched, so nothing is still in flight.
   localparam int SETTLE_CYCLES   = 6;
   localparam int RANDOM_REQUESTS = 1000;

   // Hand-made 6 x 3 frame for dark level 100: the interior holds a gap closed horizontally,
   // one closed vertically, one whose left neighbour has already been filled and that is closed
   // on the anti diagonal, plus a pixel that equals the dark level and so counts as neither
   // dark nor bright.
   localparam pixel_type CRAFTED [18] = '{
      8'd255, 8'd10,  8'd250, 8'd10,  8'd10,  8'd0,
      8'd10,  8'd250, 8'd10,  8'd250, 8'd250, 8'd100,
      8'd0,   8'd10,  8'd250, 8'd10,  8'd250, 8'd255
   };

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   gf3x3_req_if req_bus ();
   gf3x3_rsp_if rsp_bus ();

   cleaned_frame_board board;
   int unsigned        burst_left;
   int unsigned        sent_requests;

   gap_fill_3x3_filter DUT (
      .clock            (clock),
      .reset            (reset),
      .req_port         (req_bus),
      .rsp_port         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Safety net: the slowest legal run is far below this.
   initial begin
      #5ms;
      $display("tb: failure");
      $finish;
   end

   // Everything is observed at the rising edge, where the block's registered outputs
   // still hold their pre-edge values and our own inputs have been stable since the
   // falling edge. Register writes, accepted requests and accepted responses all go
   // to the scoreboard from this one place.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_enable) begin
            board.note_register(csr_index, csr_write_data);
         end
         if (req_bus.valid && req_bus.ready) begin
            board.note_request(req_bus.op, req_bus.pixel_in);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            board.check_response(rsp_bus.pixel_out, rsp_bus.frame_end);
         end
      end
   end

   // The receiver cycles through four stall behaviours in turn: always
   // ready, mostly ready, mostly stalled, and a fixed two-in-five pattern.
   initial begin : response_stall
      int unsigned    cycle_count;
      stall_mode_type mode;
      logic           take;
      rsp_bus.ready = 1'b0;
      cycle_count   = 0;
      forever begin
         @(negedge clock);
         mode = stall_mode_type'((cycle_count >> 9) % 4);
         case (mode)
            STALL_NONE:  take = 1'b1;
            STALL_LIGHT: take = ($urandom_range(0, 3) != 0);
            STALL_HEAVY: take = ($urandom_range(0, 3) == 0);
            default:     take = ((cycle_count % 5) < 2);
         endcase
         rsp_bus.ready <= take;
         cycle_count++;
      end
   end

   // Presents one request from a falling edge and holds it until it is accepted. The
   // sender works in bursts; between bursts it usually drops valid for a random gap, and now and
   // then a burst is long enough to give a stretch with no idling at all.
   task automatic send_request(logic op, pixel_type pix);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                                 : $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_bus.valid    <= 1'b1;
      req_bus.op       <= op;
      req_bus.pixel_in <= pix;
      do @(posedge clock); while (!req_bus.ready);
      sent_requests++;
      @(negedge clock);
   endtask

   // Gray values spread around the dark level, so that dark and bright neighbours are
   // common and gaps appear often; a share is fully random so every bit gets exercised.
   function automatic pixel_type pick_gray();
      int unsigned roll;
      int unsigned dk;
      roll = $urandom_range(0, 19);
      dk   = board.dark;
      if (roll < 9 && dk > 0) begin
         return pixel_type'($urandom_range(0, dk - 1));
      end
      if (roll < 16 && dk < 255) begin
         return pixel_type'($urandom_range(dk + 1, 255));
      end
      if (roll < 18) begin
         return pixel_type'(dk);
      end
      return pixel_type'($urandom);
   endfunction

   // Sends raster pixels; flush_pct sets how often a stray flush is slipped in before one.
   task automatic send_pixels(int unsigned count, int unsigned flush_pct);
      repeat (count) begin
         if ($urandom_range(0, 99) < flush_pct) begin
            send_request(OP_FLUSH, pixel_type'($urandom));
         end
         send_request(OP_PIXEL, pick_gray());
      end
   endtask

   task automatic flush_tail(int unsigned count);
      repeat (count) send_request(OP_FLUSH, pixel_type'($urandom));
   endtask

   // The sender goes quiet until every predicted pixel has come out, then waits for the settle
   // time in case the last flush is still being worked on without a result.
   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      while (board.outstanding() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Leaves the write enable high; the caller lowers it once after the last write.
   task automatic put_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
   endtask

   // Writes the selected registers back to back. The bits above each register's width
   // are filled with noise, since the block has to ignore them.
   task automatic configure(logic [3:0] which, logic [FW_W-1:0] width,
                            logic [FH_W-1:0] height, pixel_type dark, pixel_type fill);
      if (which[0]) begin
         put_register(CSR_FRAME_WIDTH, {4'($urandom), width});
      end
      if (which[1]) begin
         put_register(CSR_FRAME_HEIGHT, height);
      end
      if (which[2]) begin
         put_register(CSR_DARK_LEVEL, {8'($urandom), dark});
      end
      if (which[3]) begin
         put_register(CSR_FILL_VALUE, {8'($urandom), fill});
      end
      csr_write_enable <= 1'b0;
   endtask

   initial begin : stimulus
      logic [3:0]      which;
      logic [FW_W-1:0] next_width;
      logic [FH_W-1:0] next_height;
      pixel_type       next_dark;
      pixel_type       next_fill;
      int unsigned     roll;
      int unsigned     w;
      int unsigned     h;
      int unsigned     count;
      int unsigned     random_start;

      board            = new();
      burst_left       = 0;
      sent_requests    = 0;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = CSR_FRAME_WIDTH;
      csr_write_data   = '0;
      req_bus.valid    = 1'b0;
      req_bus.op       = OP_PIXEL;
      req_bus.pixel_in = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset geometry: with 640 pixels per row the first pixel must come out only after
      // 642 requests. Only first-row pixels are released here, and as border pixels they pass
      // through unchanged from written line buffer entries.
      send_pixels(645, 0);
      flush_tail(2);
      drain_responses();

      // A short full frame 64 pixels wide, still at the reset thresholds. It fills the
      // first 64 entries of every line store, which covers every column that a stray
      // flush can reach later, so from here on flushes may be issued at any point.
      configure(4'b0011, 12'd64, 16'd3, '0, '0);
      send_pixels(64 * 3, 0);
      flush_tail(65);
      drain_responses();

      // Hand-made frame, drained with one more flush than is pending, which must give
      // no result.
      configure(4'b1111, 12'd6, 16'd3, 8'd100, 8'd200);
      foreach (CRAFTED[i]) begin
         send_request(OP_PIXEL, CRAFTED[i]);
      end
      flush_tail(8);
      drain_responses();

      // Random part. Most rounds pause for all results and write new settings; the rest
      // carry on with the stream as it is, so frames also run across round boundaries.
      random_start = sent_requests;
      while (sent_requests - random_start < RANDOM_REQUESTS) begin
         if ($urandom_range(0, 2) != 0 || board.span() > 64) begin
            drain_responses();
            which = 4'($urandom_range(1, 15));
            if (board.span() > 64) begin
               which[0] = 1'b1;
            end
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
               next_width = FW_W'($urandom_range(3, 10));
            end else if (roll < 82) begin
               next_width = FW_W'($urandom_range(11, 40));
            end else if (roll < 92) begin
               next_width = FW_W'($urandom_range(0, 2));
            end else if (roll < 96) begin
               next_width = FW_W'($urandom_range(2049, 4095));
            end else begin
               next_width = 12'd2048;
            end
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
               next_height = FH_W'($urandom_range(3, 6));
            end else if (roll < 85) begin
               next_height = FH_W'($urandom_range(0, 2));
            end else if (roll < 95) begin
               next_height = FH_W'($urandom_range(7, 12));
            end else begin
               next_height = ($urandom_range(0, 1) == 0) ? 16'hFFFF
                                                         : FH_W'($urandom_range(13, 65535));
            end
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
               next_dark = pixel_type'($urandom_range(16, 240));
            end else if (roll < 80) begin
               next_dark = 8'd0;
            end else if (roll < 90) begin
               next_dark = 8'd255;
            end else begin
               next_dark = pixel_type'($urandom);
            end
            roll = $urandom_range(0, 9);
            next_fill = (roll == 0) ? 8'd0 : (roll == 1) ? 8'd255 : pixel_type'($urandom);
            configure(which, next_width, next_height, next_dark, next_fill);
         end

         w = board.span();
         h = board.depth_rows();
         if (w * h > 800) begin
            // Frames too big to run whole: a stretch of rows with stray flushes. A frame wider than 64
            // forces a width write on the next round, which restarts the stream.
            count = (w > 64) ? w + 2 + $urandom_range(0, 40)
                             : w * $urandom_range(2, 5) + $urandom_range(0, w - 1);
            send_pixels(count, 2);
            flush_tail($urandom_range(0, (w > 64) ? 40 : w + 3));
         end else begin
            repeat ($urandom_range(1, 3)) begin
               send_pixels(w * h, ($urandom_range(0, 2) == 0) ? 3 : 0);
               // Either drain the tail (sometimes with spare flushes that give nothing),
               // go straight on into the next frame, or drain only part of it.
               roll = $urandom_range(0, 99);
               if (roll < 55) begin
                  flush_tail(w + 1 + $urandom_range(0, 2));
               end else if (roll >= 80) begin
                  flush_tail($urandom_range(1, w));
               end
            end
         end
      end

      drain_responses();
      if (board.failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/gf3x3_pkg.sv
hw/rtl/gf3x3_if.sv
hw/rtl/gf3x3_ram.sv
hw/rtl/gf3x3_track.sv
hw/rtl/gf3x3_gap_test.sv
hw/rtl/gap_fill_3x3_filter.sv
tb/sv/gf3x3_board_pkg.sv
tb/sv/testbench.sv
